// ----- rtl/lc2bc_pkg.sv -----
// Shared types and character constants for the line-to-block comment rewriter.
package lc2bc_pkg;

   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   localparam logic [1:0] END_NONE  = 2'd0;
   localparam logic [1:0] END_CLEAN = 2'd1;
   localparam logic [1:0] END_BAD   = 2'd2;

   localparam int MAX_RESULTS     = 4;
   localparam int CMD_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } lc2bc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       nested_close_warning;
      logic [1:0] end_status;
   } lc2bc_rsp_type;

   // One classified item: up to four bytes to emit, plus flags.
   typedef struct packed {
      logic [2:0]                   count;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
      logic                         has_byte;
      logic                         warn;
      logic [1:0]                   status;
   } lc2bc_cmd_type;

endpackage

// ----- rtl/line_comment_to_block_comment.sv -----
// Top level of the line-to-block comment rewriter.
/*
 * Rewrites C source so that every line comment becomes a block comment.
 * Source bytes arrive one per transfer on the req_ channel; an item with
 * end_of_input set closes the current file and reports its end status.
 * A front end tracks the lexical state (code, literals, escapes, comments)
 * and turns each item into a command of zero to four output bytes; a small
 * queue passes commands to a back end that sends one result per transfer on
 * the rsp_ channel. Input is taken every cycle while the queue has room, and
 * results leave at one per cycle: an item with k results occupies the back
 * end for k cycles, and a slash in code, which is held back, uses none.
 * At the earliest, the first result of an item is offered one cycle after
 * its transfer and can be taken at the edge after that. The rsp_
 * payload comes straight from back-end registers, so a stall on the result
 * side never reaches the input until the queue fills.
 */
module line_comment_to_block_comment import lc2bc_pkg::*; #(
   parameter int QueueDepth = CMD_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  lc2bc_req_type req_payload,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output lc2bc_rsp_type rsp_payload
);

   logic          req_xfer;
   logic          push;
   lc2bc_cmd_type cmd;
   lc2bc_cmd_type q_data;
   logic          q_pop, q_empty, q_full;

   // Stall only on a full queue; the front end never waits otherwise.
   assign req_stall = q_full;
   assign req_xfer  = req_valid && !req_stall;

   lc2bc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_xfer),
      .item   (req_payload),
      .push   (push),
      .cmd    (cmd)
   );

   lc2bc_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   lc2bc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_payload)
   );

endmodule

// ----- rtl/lc2bc_front.sv -----
// Front end: lexical state tracking and classification of each input item.
module lc2bc_front import lc2bc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  lc2bc_req_type item,
   output logic          push,
   output lc2bc_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CODE    = 4'd0,
      ST_CHR     = 4'd1,
      ST_CHR_ESC = 4'd2,
      ST_STR     = 4'd3,
      ST_STR_ESC = 4'd4,
      ST_SLASH   = 4'd5,
      ST_LINE    = 4'd6,
      ST_LINE_AS = 4'd7,
      ST_BLOCK   = 4'd8,
      ST_STAR    = 4'd9
   } lex_state_type;

   lex_state_type state_ff, state_in;
   logic [7:0]    c;

   assign c = item.in_byte;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (item.end_of_input) begin
         state_in = ST_CODE;
         if (state_ff == ST_LINE) begin
            cmd.count    = 3'd3;
            cmd.has_byte = 1'b1;
            cmd.bytes[0] = CHAR_SPACE;
            cmd.bytes[1] = CHAR_STAR;
            cmd.bytes[2] = CHAR_SLASH;
            cmd.status   = END_CLEAN;
         end else if (state_ff == ST_CODE) begin
            cmd.count  = 3'd1;
            cmd.status = END_CLEAN;
         end else begin
            cmd.count  = 3'd1;
            cmd.status = END_BAD;
         end
      end else begin
         cmd.has_byte = 1'b1;
         cmd.count    = 3'd1;
         cmd.bytes[0] = c;
         unique case (state_ff)
            ST_CODE: begin
               if (c == CHAR_DQUOTE) state_in = ST_STR;
               else if (c == CHAR_SQUOTE) state_in = ST_CHR;
               else if (c == CHAR_SLASH) begin
                  // held back until the next byte decides
                  state_in  = ST_SLASH;
                  cmd.count = 3'd0;
               end
            end
            ST_STR: begin
               if (c == CHAR_BSLASH) state_in = ST_STR_ESC;
               else if (c == CHAR_DQUOTE) state_in = ST_CODE;
            end
            ST_STR_ESC: state_in = ST_STR;
            ST_CHR: begin
               if (c == CHAR_BSLASH) state_in = ST_CHR_ESC;
               else if (c == CHAR_SQUOTE) state_in = ST_CODE;
            end
            ST_CHR_ESC: state_in = ST_CHR;
            ST_SLASH: begin
               cmd.count    = 3'd2;
               cmd.bytes[0] = CHAR_SLASH;
               if (c == CHAR_SLASH) begin
                  state_in     = ST_LINE;
                  cmd.bytes[1] = CHAR_STAR;
               end else if (c == CHAR_STAR) begin
                  state_in     = ST_BLOCK;
                  cmd.bytes[1] = CHAR_STAR;
               end else begin
                  state_in     = ST_CODE;
                  cmd.bytes[1] = c;
               end
            end
            ST_LINE, ST_LINE_AS: begin
               if (c == CHAR_NL) begin
                  state_in     = ST_CODE;
                  cmd.count    = 3'd4;
                  cmd.bytes[0] = CHAR_SPACE;
                  cmd.bytes[1] = CHAR_STAR;
                  cmd.bytes[2] = CHAR_SLASH;
                  cmd.bytes[3] = c;
               end else if (c == CHAR_STAR) begin
                  state_in = ST_LINE_AS;
               end else if (c == CHAR_SLASH && state_ff == ST_LINE_AS) begin
                  // split the star-slash so the rewritten comment stays open
                  state_in     = ST_LINE;
                  cmd.count    = 3'd2;
                  cmd.bytes[0] = CHAR_SPACE;
                  cmd.bytes[1] = c;
                  cmd.warn     = 1'b1;
               end else begin
                  state_in = ST_LINE;
               end
            end
            ST_BLOCK: begin
               if (c == CHAR_STAR) state_in = ST_STAR;
            end
            ST_STAR: begin
               if (c == CHAR_SLASH) state_in = ST_CODE;
               else if (c != CHAR_STAR) state_in = ST_BLOCK;
            end
            default: state_in = ST_CODE;
         endcase
      end
   end

   assign push = accept && (cmd.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CODE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lc2bc_queue.sv -----
// Small register queue of classified items between front and back end.
module lc2bc_queue import lc2bc_pkg::*; #(
   parameter int DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  lc2bc_cmd_type push_data,
   input  logic          pop,
   output lc2bc_cmd_type pop_data,
   output logic          empty,
   output logic          full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   lc2bc_cmd_type     mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ----- rtl/lc2bc_back.sv -----
// Back end: walks each classified item out as one result per transfer.
module lc2bc_back import lc2bc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  lc2bc_cmd_type q_data,
   output logic          q_pop,
   output logic          out_valid,
   input  logic          out_stall,
   output lc2bc_rsp_type out_item
);

   lc2bc_cmd_type cur_ff;
   logic          cur_valid_ff;
   logic [1:0]    idx_ff;
   logic          is_last;
   logic          done;

   assign is_last = ({1'b0, idx_ff} == (cur_ff.count - 3'd1));
   assign done    = !cur_valid_ff || (!out_stall && is_last);
   assign q_pop   = done && !q_empty;

   assign out_valid                     = cur_valid_ff;
   assign out_item.out_byte             = cur_ff.has_byte ? cur_ff.bytes[idx_ff] : 8'd0;
   assign out_item.byte_valid           = cur_ff.has_byte;
   assign out_item.last_of_run          = is_last;
   assign out_item.nested_close_warning = cur_ff.warn;
   assign out_item.end_status           = is_last ? cur_ff.status : END_NONE;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (done) begin
         cur_valid_ff <= !q_empty;
         idx_ff       <= '0;
      end else if (!out_stall) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the line-to-block comment rewriter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lc2bc_pkg::*;

   /*
    * Run sizing. The worst item costs a source gap of 17 cycles plus four
    * results, each of which can sit out a 17-cycle stall. That is about 90
    * cycles an item. The cycle limit is several times that over the whole run.
    */
   localparam int RANDOM_ITEMS = 320;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_GAP      = 17;

   // Lexical states of the predictor. The encoding is private to the testbench.
   typedef enum logic [3:0] {
      LEX_CODE,
      LEX_CHR,
      LEX_CHR_ESC,
      LEX_STR,
      LEX_STR_ESC,
      LEX_SLASH,
      LEX_LINE,
      LEX_LINE_STAR,
      LEX_BLOCK,
      LEX_BLOCK_STAR
   } lex_state_type;

   /*
    * Rewrite predictor plus the store of rewritten bytes still awaited.
    * Each accepted source item is run through the lexer here. The output
    * transfers it should cause are queued in order.
    */
   class rewrite_scoreboard;
      lex_state_type lex;
      lc2bc_rsp_type awaited[$];
      int            mismatch_count;

      function new();
         lex            = LEX_CODE;
         mismatch_count = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report_mismatch(input string what, input logic [7:0] got,
                           input logic [7:0] want);
         mismatch_count++;
         $display("[%0t] %s: got 'h%0h, want 'h%0h", $realtime, what, got, want);
      endtask

      function void note_source_item(input lc2bc_req_type item);
         logic [7:0]    c;
         logic [7:0]    emits[$];
         logic          warn;
         logic [1:0]    status;
         lc2bc_rsp_type r;
         c      = item.in_byte;
         warn   = 1'b0;
         status = END_NONE;
         if (item.end_of_input) begin
            // an open line comment gets closed, anything else open is bad
            status = (lex == LEX_CODE || lex == LEX_LINE) ? END_CLEAN : END_BAD;
            if (lex == LEX_LINE) begin
               emits.push_back(CHAR_SPACE);
               emits.push_back(CHAR_STAR);
               emits.push_back(CHAR_SLASH);
            end
            lex = LEX_CODE;
         end else begin
            case (lex)
               LEX_CODE: begin
                  if (c == CHAR_DQUOTE) begin
                     lex = LEX_STR;
                     emits.push_back(c);
                  end else if (c == CHAR_SQUOTE) begin
                     lex = LEX_CHR;
                     emits.push_back(c);
                  end else if (c == CHAR_SLASH) begin
                     lex = LEX_SLASH;
                  end else begin
                     emits.push_back(c);
                  end
               end
               LEX_STR: begin
                  if (c == CHAR_BSLASH) lex = LEX_STR_ESC;
                  else if (c == CHAR_DQUOTE) lex = LEX_CODE;
                  emits.push_back(c);
               end
               LEX_STR_ESC: begin
                  lex = LEX_STR;
                  emits.push_back(c);
               end
               LEX_CHR: begin
                  if (c == CHAR_BSLASH) lex = LEX_CHR_ESC;
                  else if (c == CHAR_SQUOTE) lex = LEX_CODE;
                  emits.push_back(c);
               end
               LEX_CHR_ESC: begin
                  lex = LEX_CHR;
                  emits.push_back(c);
               end
               LEX_SLASH: begin
                  emits.push_back(CHAR_SLASH);
                  if (c == CHAR_SLASH) begin
                     lex = LEX_LINE;
                     emits.push_back(CHAR_STAR);
                  end else if (c == CHAR_STAR) begin
                     lex = LEX_BLOCK;
                     emits.push_back(CHAR_STAR);
                  end else begin
                     lex = LEX_CODE;
                     emits.push_back(c);
                  end
               end
               LEX_LINE, LEX_LINE_STAR: begin
                  if (c == CHAR_NL) begin
                     lex = LEX_CODE;
                     emits.push_back(CHAR_SPACE);
                     emits.push_back(CHAR_STAR);
                     emits.push_back(CHAR_SLASH);
                     emits.push_back(c);
                  end else if (c == CHAR_STAR) begin
                     lex = LEX_LINE_STAR;
                     emits.push_back(c);
                  end else if (c == CHAR_SLASH && lex == LEX_LINE_STAR) begin
                     // split the closer so the block comment stays open
                     lex  = LEX_LINE;
                     warn = 1'b1;
                     emits.push_back(CHAR_SPACE);
                     emits.push_back(c);
                  end else begin
                     lex = LEX_LINE;
                     emits.push_back(c);
                  end
               end
               LEX_BLOCK: begin
                  if (c == CHAR_STAR) lex = LEX_BLOCK_STAR;
                  emits.push_back(c);
               end
               LEX_BLOCK_STAR: begin
                  if (c == CHAR_SLASH) lex = LEX_CODE;
                  else if (c != CHAR_STAR) lex = LEX_BLOCK;
                  emits.push_back(c);
               end
               default: begin
                  lex = LEX_CODE;
                  emits.push_back(c);
               end
            endcase
         end

         if (item.end_of_input && emits.size() == 0) begin
            r             = '0;
            r.last_of_run = 1'b1;
            r.end_status  = status;
            awaited.push_back(r);
         end
         foreach (emits[i]) begin
            r                      = '0;
            r.out_byte             = emits[i];
            r.byte_valid           = 1'b1;
            r.nested_close_warning = warn;
            r.last_of_run          = (i == emits.size() - 1);
            r.end_status           = r.last_of_run ? status : END_NONE;
            awaited.push_back(r);
         end
      endfunction

      task check_output_item(input lc2bc_rsp_type got);
         lc2bc_rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch("output transfer with none awaited, out_byte",
                            got.out_byte, 8'h00);
            return;
         end
         want = awaited.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
         if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
         if (got.nested_close_warning !== want.nested_close_warning)
            report_mismatch("nested_close_warning", 8'(got.nested_close_warning),
                            8'(want.nested_close_warning));
         if (got.end_status !== want.end_status)
            report_mismatch("end_status", 8'(got.end_status), 8'(want.end_status));
      endtask
   endclass

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   lc2bc_req_type req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b1;
   lc2bc_rsp_type rsp_payload;

   rewrite_scoreboard sb = new();
   int                items_sent  = 0;
   int                cycle_count = 0;
   // While a quiet flag is set, that side runs without idle cycles.
   bit                req_quiet   = 1'b0;
   bit                rsp_quiet   = 1'b0;

   line_comment_to_block_comment u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   /*
    * Monitor. Both channels are sampled at the rising edge. A source
    * transfer is noted before the output transfer of the same edge. That
    * order is harmless, because output lags its source by at least two
    * cycles.
    */
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_source_item(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_output_item(rsp_payload);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_comment_to_block_comment: mismatch");
         $finish;
      end
   end

   /*
    * Source driver. Entered and left at a falling edge. It idles for a drawn
    * number of cycles, then holds valid and payload until the transfer is
    * taken. Valid stays high on return, so a back-to-back item needs only
    * one assignment in that time step.
    */
   task automatic send_item(input lc2bc_req_type item);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_char(input logic [7:0] c);
      lc2bc_req_type item;
      item.in_byte      = c;
      item.end_of_input = 1'b0;
      send_item(item);
   endtask

   // The byte field of an end item is don't-care, so it carries noise.
   task automatic send_end_item();
      lc2bc_req_type item;
      item.in_byte      = 8'($urandom_range(0, 255));
      item.end_of_input = 1'b1;
      send_item(item);
   endtask

   // Hold the source off until every awaited output transfer has arrived.
   // Always leaves at a later falling edge than it entered.
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Comment bodies get many stars and slashes, so closers and splits come up.
   function automatic logic [7:0] comment_char();
      case ($urandom_range(0, 5))
         0, 1:    return CHAR_STAR;
         2:       return CHAR_SLASH;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_line_comment();
      int n;
      n = $urandom_range(0, 6);
      send_char(CHAR_SLASH);
      send_char(CHAR_SLASH);
      repeat (n) send_char(comment_char());
      if ($urandom_range(0, 9) == 0) send_end_item();
      else send_char(CHAR_NL);
   endtask

   task automatic send_block_comment();
      int n;
      n = $urandom_range(0, 6);
      send_char(CHAR_SLASH);
      send_char(CHAR_STAR);
      repeat (n) send_char(comment_char());
      send_char(CHAR_STAR);
      send_char(CHAR_SLASH);
   endtask

   // String or character literal with random body and escapes.
   task automatic send_literal(input logic [7:0] quote, input int max_len);
      int n;
      n = $urandom_range(0, max_len);
      send_char(quote);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) send_char(CHAR_BSLASH);
         send_char(8'($urandom_range(0, 255)));
      end
      send_char(quote);
   endtask

   /*
    * Output side. For every output transfer it draws a stall length and then
    * takes the transfer. The quiet flag is redrawn now and then, so some
    * stretches run without any stall.
    */
   initial begin : rsp_side
      int hold;
      int taken;
      taken = 0;
      while (reset) @(negedge clock);
      forever begin
         if (taken % 25 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         hold = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      int pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      /*
       * Directed part. Byte extremes in code, then a held slash resolved
       * into a plain slash. A line comment with a split closer ends on a
       * star at end of input, which counts as bad. A block comment runs
       * through repeated stars. String and char literals carry escaped
       * quotes. A line comment is closed by a newline and another by end
       * of input. A pending slash dropped at end of input is bad, and an
       * end in code is clean.
       */
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CHAR_SLASH);
      send_char(8'h78);
      send_char(CHAR_SLASH);
      send_char(CHAR_SLASH);
      send_char(CHAR_STAR);
      send_char(CHAR_SLASH);
      send_char(CHAR_STAR);
      send_end_item();
      send_char(CHAR_SLASH);
      send_char(CHAR_STAR);
      send_char(CHAR_STAR);
      send_char(CHAR_STAR);
      send_char(8'hFF);
      send_char(CHAR_STAR);
      send_char(CHAR_SLASH);
      send_char(CHAR_DQUOTE);
      send_char(CHAR_BSLASH);
      send_char(CHAR_DQUOTE);
      send_char(CHAR_DQUOTE);
      send_char(CHAR_SQUOTE);
      send_char(CHAR_BSLASH);
      send_char(CHAR_SQUOTE);
      send_char(CHAR_SQUOTE);
      send_char(CHAR_SLASH);
      send_char(CHAR_SLASH);
      send_char(CHAR_NL);
      send_char(CHAR_SLASH);
      send_char(CHAR_SLASH);
      send_end_item();
      send_char(CHAR_SLASH);
      send_end_item();
      send_end_item();
      drain_pause();

      /*
       * Random part. Most transfers form well-formed comments and literals
       * with random content. The rest is noise bytes, stray slashes and end
       * items that fall in any state.
       */
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent % 40 < 4) req_quiet = ($urandom_range(0, 3) == 0);
         if (items_sent >= RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 6)
            drain_pause();
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_char(8'($urandom_range(0, 255)));
         end else if (pick < 45) begin
            send_line_comment();
         end else if (pick < 58) begin
            send_block_comment();
         end else if (pick < 70) begin
            send_literal(CHAR_DQUOTE, 5);
         end else if (pick < 78) begin
            send_literal(CHAR_SQUOTE, 2);
         end else if (pick < 88) begin
            send_char(CHAR_SLASH);
            send_char(8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            send_end_item();
         end else begin
            send_char(comment_char());
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("line_comment_to_block_comment: match");
      end else begin
         $display("line_comment_to_block_comment: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lc2bc_pkg.sv
rtl/lc2bc_front.sv
rtl/lc2bc_queue.sv
rtl/lc2bc_back.sv
rtl/line_comment_to_block_comment.sv
verif/testbench.sv
